@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define CHK_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a cause is followed by an effect in the next cycle.
`define CHK_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

// Checks that a cause implies an effect in the same cycle.
`define CHK_SAME(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("assertion failed");

`endif

@@ rtl/hao_pkg.sv @@
package hao_pkg;

    localparam int NUM_HARMONICS_DEF   = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 24;

    localparam int IN_PHASE_W = 24;
    localparam int SAMPLE_W   = 28;
    localparam int COEF_W     = 8;
    localparam int SINE_W     = 16;
    localparam int MAX_COEFS  = 16;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_FIXED_STEP  = 3'd1;
    localparam logic [2:0] REG_START_PHASE = 3'd2;
    localparam logic [2:0] REG_HZ_SCALE    = 3'd3;
    localparam logic [2:0] REG_COEF_LOW    = 3'd4;
    localparam logic [2:0] REG_COEF_HIGH   = 3'd5;

    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_RATE  = 2'd1;
    localparam logic [1:0] MODE_PHASE = 2'd2;
    // The spare code behaves as phase mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] SINE_AMP    = 64'd32767;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] fixed_step;
        logic [23:0] start_phase;
        logic [31:0] hz_scale;
    } cfg_t;

    // Quarter-wave sine entry, Q1.15, from a Q30 Taylor series through x^11.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i,
                                                       input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        x  = (64'(i) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        v  = (((x * t) >> 30) * SINE_AMP + 64'd536870912) >> 30;
        if (v > SINE_AMP)
        begin
            v = SINE_AMP;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

@@ rtl/hao_fifo.sv @@
module hao_fifo import hao_pkg::*;
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign do_wr = wr_en && (count_reg != CW'(DEPTH));
    assign do_rd = rd_en && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

@@ rtl/hao_front.sv @@
module hao_front import hao_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   accept,
    input  logic                   op,
    input  logic signed [23:0]     rate_hz,
    input  logic [IN_PHASE_W-1:0]  phase_in,
    output logic                   q_push,
    output logic [PHASE_BITS-1:0]  q_phase
);

    logic [PHASE_BITS-1:0] acc_reg, acc_next;
    logic [PHASE_BITS-1:0] inc;
    logic signed [32:0]    scale_s;
    logic signed [56:0]    prod;
    logic [31:0]           in_ext, step_ext, start_ext;

    assign in_ext    = 32'(phase_in);
    assign step_ext  = 32'(cfg.fixed_step);
    assign start_ext = 32'(cfg.start_phase);
    assign scale_s   = signed'({1'b0, cfg.hz_scale});
    assign prod      = 57'(rate_hz) * 57'(scale_s);

    always_comb
    begin
        if (cfg.mode == MODE_FIXED)
        begin
            inc = step_ext[PHASE_BITS-1:0];
        end
        else
        begin
            inc = prod[24 +: PHASE_BITS];
        end
    end

    // Restarts only touch the accumulator; samples go on to the queue.
    always_comb
    begin
        acc_next = acc_reg;
        q_push   = 1'b0;
        q_phase  = acc_reg;
        if (accept)
        begin
            if (op)
            begin
                acc_next = start_ext[PHASE_BITS-1:0];
            end
            else if (cfg.mode[1])
            begin
                q_push  = 1'b1;
                q_phase = in_ext[PHASE_BITS-1:0];
            end
            else
            begin
                q_push   = 1'b1;
                acc_next = acc_reg + inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ rtl/hao_synth.sv @@
module hao_synth import hao_pkg::*;
#(
    parameter int NUM_HARMONICS   = NUM_HARMONICS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        issue,
    input  logic [PHASE_BITS-1:0]       phase,
    input  logic [63:0]                 coef_low,
    input  logic [63:0]                 coef_high,
    output logic [2:0]                  inflight,
    output logic                        res_valid,
    output logic signed [SAMPLE_W-1:0]  res_sample
);

    localparam int QB     = SINE_TABLE_BITS - 2;
    localparam int QLEN   = 1 << QB;
    localparam int PROD_W = COEF_W + SINE_W + 1;
    localparam int NGRP   = (NUM_HARMONICS + 3) / 4;
    localparam int SUM_W  = PROD_W + $clog2(NUM_HARMONICS) + 1;

    logic signed [SINE_W-1:0] qtab [QLEN+1];

    for (genvar gi = 0; gi <= QLEN; gi++)
    begin : g_tab
        assign qtab[gi] = signed'(quarter_sine(gi, QB));
    end

    logic [127:0] coefs;
    assign coefs = {coef_high, coef_low};

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [SINE_W-1:0] sine1_reg [NUM_HARMONICS];
    logic signed [SINE_W-1:0] sine1_next [NUM_HARMONICS];
    logic signed [PROD_W-1:0] prod2_reg [NUM_HARMONICS];
    logic signed [PROD_W-1:0] prod2_next [NUM_HARMONICS];
    logic signed [SUM_W-1:0]  part3_reg [NGRP];
    logic signed [SUM_W-1:0]  part3_next [NGRP];
    logic signed [SUM_W-1:0]  sum4_reg, sum4_next;
    logic signed [31:0]       sum_ext;

    // Stage 1: harmonic phases and quarter-wave lookups.
    always_comb
    begin
        logic [PHASE_BITS-1:0]    pk;
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [QB:0]              tidx;
        logic signed [SINE_W-1:0] v;
        for (int h = 0; h < NUM_HARMONICS; h++)
        begin
            pk   = PHASE_BITS'(phase * PHASE_BITS'(h + 1));
            idx  = pk[PHASE_BITS-1 -: SINE_TABLE_BITS];
            if (idx[QB])
            begin
                tidx = (QB+1)'(QLEN) - {1'b0, idx[QB-1:0]};
            end
            else
            begin
                tidx = {1'b0, idx[QB-1:0]};
            end
            v = qtab[tidx];
            sine1_next[h] = idx[QB+1] ? -v : v;
        end
    end

    // Stage 2: coefficient products.
    always_comb
    begin
        logic [COEF_W-1:0] c;
        for (int h = 0; h < NUM_HARMONICS; h++)
        begin
            c = (h < MAX_COEFS) ? coefs[8*h +: 8] : '0;
            prod2_next[h] = PROD_W'(signed'({1'b0, c}) * sine1_reg[h]);
        end
    end

    // Stage 3: sums of four products each.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            part3_next[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (4 * g + j < NUM_HARMONICS)
                begin
                    part3_next[g] = part3_next[g] + SUM_W'(prod2_reg[4*g + j]);
                end
            end
        end
    end

    // Stage 4: final sum of the group sums.
    always_comb
    begin
        sum4_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum4_next = sum4_next + part3_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sine1_reg <= sine1_next;
        prod2_reg <= prod2_next;
        part3_reg <= part3_next;
        sum4_reg  <= sum4_next;
    end

    assign sum_ext    = 32'(sum4_reg);
    assign res_sample = sum_ext[SAMPLE_W-1:0];
    assign res_valid  = v4_reg;
    assign inflight   = 3'(v1_reg) + 3'(v2_reg) + 3'(v3_reg) + 3'(v4_reg);

endmodule

@@ rtl/harmonic_additive_oscillator_core.sv @@
// A sample request passes the phase queue, the four-stage pipeline and the result queue.
// Throughput: one request per cycle unless stalled; the pipeline takes one phase a cycle.
// The input stalls only when the phase queue fills, which happens when results are not popped.
// Reset clears the phase accumulator, the queues and the registers to their defaults
// (coefficient byte of the fundamental 255, all else zero).
module harmonic_additive_oscillator_core import hao_pkg::*;
#(
    parameter int NUM_HARMONICS   = NUM_HARMONICS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        op,
    input  logic signed [23:0]          rate_hz,
    input  logic [IN_PHASE_W-1:0]       phase_in,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [63:0]                 cfg_data
);

    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam int MCW = $clog2(MID_DEPTH + 1);

    cfg_t        cfg_reg;
    logic [63:0] coef_low_reg, coef_high_reg;
    logic        accept;
    logic        q_push;
    logic [PHASE_BITS-1:0] q_phase, mid_phase;
    logic        mid_empty;
    logic [MCW-1:0] mid_count;
    logic        issue;
    logic [2:0]  inflight;
    logic        res_valid;
    logic signed [SAMPLE_W-1:0] res_sample;
    logic [OCW-1:0] out_count;
    logic        out_full;
    logic [OCW:0] committed;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            coef_low_reg  <= 64'd255;
            coef_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:        cfg_reg.mode        <= cfg_data[1:0];
                REG_FIXED_STEP:  cfg_reg.fixed_step  <= cfg_data[23:0];
                REG_START_PHASE: cfg_reg.start_phase <= cfg_data[23:0];
                REG_HZ_SCALE:    cfg_reg.hz_scale    <= cfg_data[31:0];
                REG_COEF_LOW:    coef_low_reg        <= cfg_data;
                REG_COEF_HIGH:   coef_high_reg       <= cfg_data;
                default:         ;
            endcase
        end
    end

    hao_front #(.PHASE_BITS(PHASE_BITS)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .op       (op),
        .rate_hz  (rate_hz),
        .phase_in (phase_in),
        .q_push   (q_push),
        .q_phase  (q_phase)
    );

    hao_fifo #(.WIDTH(PHASE_BITS), .DEPTH(MID_DEPTH)) u_mid_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_phase),
        .rd_en   (issue),
        .rd_data (mid_phase),
        .full    (full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    // A phase enters the pipeline only if the result queue has room for it
    // and for everything already in flight.
    assign committed = (OCW+1)'(out_count) + (OCW+1)'(inflight);
    assign issue     = !mid_empty && !out_full && (committed < (OCW+1)'(OUT_DEPTH))
                       && (mid_count != '0);

    hao_synth #(
        .NUM_HARMONICS   (NUM_HARMONICS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_synth
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .phase      (mid_phase),
        .coef_low   (coef_low_reg),
        .coef_high  (coef_high_reg),
        .inflight   (inflight),
        .res_valid  (res_valid),
        .res_sample (res_sample)
    );

    hao_fifo #(.WIDTH(SAMPLE_W), .DEPTH(OUT_DEPTH)) u_out_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_sample),
        .rd_en   (pop),
        .rd_data (sample),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

endmodule

@@ rtl/hao_checker.sv @@
`include "assert_macros.svh"

module hao_checker import hao_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic signed [SAMPLE_W-1:0]  sample,
    input logic                        cfg_ready
);

    // The register port never stalls a write.
    `CHK_ALWAYS(a_cfg_ready, cfg_ready)

    // Sixteen full-scale harmonics bound every result.
    `CHK_SAME(a_sample_range, !empty,
        (sample <= 28'sd133689360) && (sample >= -28'sd133689360))

    // A waiting result holds until it is popped.
    `CHK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(sample))

    // The input queue only fills as a result of an incoming request.
    `CHK_SAME(a_full_cause, $rose(full), $past(push))

endmodule

bind harmonic_additive_oscillator_core hao_checker u_hao_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import hao_pkg::*;

    localparam int QLEN      = 256;
    localparam int LIMIT_CYC = 400000;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       op;
    logic signed [23:0]         rate_hz;
    logic [IN_PHASE_W-1:0]      phase_in;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [2:0]                 cfg_index;
    logic [63:0]                cfg_data;

    harmonic_additive_oscillator_core u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .rate_hz(rate_hz), .phase_in(phase_in), .empty(empty), .pop(pop),
        .sample(sample), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Oscillator model: register copy, phase accumulator and sine table.
    class osc_scoreboard_t;
        logic [1:0]          mode;
        logic [23:0]         fixed_step;
        logic [23:0]         start_phase;
        logic [31:0]         hz_scale;
        logic [63:0]         coef_lo;
        logic [63:0]         coef_hi;
        logic [23:0]         acc;
        logic [15:0]         qsine [0:QLEN];
        logic [SAMPLE_W-1:0] pending [$];
        int                  mismatches;

        function void init();
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] v;
            for (int i = 0; i <= QLEN; i++)
            begin
                x  = (64'(i) * 64'd1686629713) >> 8;
                x2 = (x * x) >> 30;
                t  = 64'd1073741824 - x2 / 110;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
                v  = (((x * t) >> 30) * 64'd32767 + 64'd536870912) >> 30;
                if (v > 64'd32767)
                begin
                    v = 64'd32767;
                end
                qsine[i] = v[15:0];
            end
            mode = MODE_FIXED;
            fixed_step = '0;
            start_phase = '0;
            hz_scale = '0;
            coef_lo = 64'd255;
            coef_hi = '0;
            acc = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_MODE:        mode = data[1:0];
                REG_FIXED_STEP:  fixed_step = data[23:0];
                REG_START_PHASE: start_phase = data[23:0];
                REG_HZ_SCALE:    hz_scale = data[31:0];
                REG_COEF_LOW:    coef_lo = data;
                REG_COEF_HIGH:   coef_hi = data;
                default: ;
            endcase
        endfunction

        function longint sine_at(logic [23:0] ph);
            logic [9:0] idx;
            longint     v;
            idx = ph[23:14];
            v = idx[8] ? longint'(qsine[QLEN - idx[7:0]]) : longint'(qsine[idx[7:0]]);
            return idx[9] ? -v : v;
        endfunction

        function logic [SAMPLE_W-1:0] harmonic_sum(logic [23:0] ph);
            longint      sum;
            logic [7:0]  c;
            logic [23:0] pk;
            sum = 0;
            for (int k = 1; k <= 16; k++)
            begin
                c = (k <= 8) ? coef_lo[8*(k-1) +: 8] : coef_hi[8*(k-9) +: 8];
                pk = 24'(ph * k);
                sum += longint'(c) * sine_at(pk);
            end
            return sum[SAMPLE_W-1:0];
        endfunction

        function void note_request(logic o, logic signed [23:0] rate, logic [23:0] ph);
            longint prod;
            if (o)
            begin
                acc = start_phase;
                return;
            end
            if (mode[1])
            begin
                pending.push_back(harmonic_sum(ph));
            end
            else
            begin
                pending.push_back(harmonic_sum(acc));
                if (mode == MODE_FIXED)
                begin
                    acc = acc + fixed_step;
                end
                else
                begin
                    prod = longint'(rate) * longint'({1'b0, hz_scale});
                    acc = acc + 24'(prod >>> 24);
                end
            end
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d", $signed(got));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sample mismatch: expected %0d, actual %0d",
                             $signed(want), $signed(got));
            end
        endfunction
    endclass

    osc_scoreboard_t sb;
    int              cycles = 0;
    int              hold_cycles = 0;
    int              hold_reqs = 0;
    int              hold_seen = 0;
    bit              allow_stall;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: pops every cycle, or at random when stalls are allowed, with a long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(sample);
        if (hold_seen != hold_reqs)
        begin
            hold_seen   <= hold_reqs;
            hold_cycles <= 200;
            pop <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= !allow_stall || ($urandom_range(0, 14) < 5);
    end

    task automatic send_request(logic o, logic signed [23:0] rate, logic [23:0] ph);
        int gap;
        gap = allow_stall ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        op       <= o;
        rate_hz  <= rate;
        phase_in <= ph;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_request(o, rate, ph);
    endtask

    task automatic drain();
        push      <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        push      <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_requests(int n);
        for (int i = 0; i < n; i++)
            send_request($urandom_range(0, 19) == 0, 24'($urandom()), 24'($urandom()));
    endtask

    initial
    begin
        sb = new();
        sb.init();
        allow_stall = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        op = 1'b0;
        rate_hz = '0;
        phase_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, then extremes in every mode.
        send_request(1'b0, '0, '0);
        send_request(1'b0, '0, '0);
        drain();
        write_reg(REG_FIXED_STEP, 64'hFFFFFF);
        write_reg(REG_START_PHASE, 64'h400000);
        write_reg(REG_COEF_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEF_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(1'b1, '0, '0);
        send_request(1'b0, '0, '0);
        send_request(1'b0, '0, '0);
        drain();
        write_reg(REG_MODE, 64'(MODE_RATE));
        write_reg(REG_HZ_SCALE, 64'hFFFF_FFFF);
        send_request(1'b0, 24'sh7FFFFF, '0);
        send_request(1'b0, 24'sh800000, '0);
        send_request(1'b0, -24'sd1, '0);
        send_request(1'b1, '0, '0);
        send_request(1'b0, 24'sd256, '0);
        drain();
        write_reg(REG_MODE, 64'(MODE_PHASE));
        send_request(1'b0, '0, 24'hFFFFFF);
        send_request(1'b0, '0, 24'h400000);
        send_request(1'b0, '0, 24'h000001);
        drain();
        write_reg(REG_MODE, 64'(MODE_SPARE));
        send_request(1'b0, '0, 24'h123456);
        send_request(1'b1, '0, 24'h800000);
        drain();
        write_reg(REG_COEF_LOW, 64'd0);
        write_reg(REG_COEF_HIGH, 64'd0);
        send_request(1'b0, '0, 24'h2AAAAA);
        drain();

        // Random phases across settings.
        allow_stall = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_MODE, (ph == 0) ? 64'(MODE_PHASE) : 64'($urandom_range(0, 3)));
            write_reg(REG_FIXED_STEP, (ph == 1) ? 64'd0 : rand64());
            write_reg(REG_START_PHASE, rand64());
            write_reg(REG_HZ_SCALE, (ph == 2) ? 64'd0 : rand64());
            write_reg(REG_COEF_LOW, (ph == 3) ? 64'd0 : rand64());
            write_reg(REG_COEF_HIGH, (ph == 4) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64());
            if (ph == 5)
            begin
                // Hold off the receiver so the queues fill and push stalls.
                hold_reqs++;
                allow_stall = 1'b0;
                random_requests(60);
                allow_stall = 1'b1;
            end
            random_requests(130);
            drain();
        end

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/hao_pkg.sv
rtl/hao_fifo.sv
rtl/hao_front.sv
rtl/hao_synth.sv
rtl/harmonic_additive_oscillator_core.sv
rtl/hao_checker.sv
test/tb.sv
